// File: rtl/csl_pkg.sv
package csl_pkg;

    localparam int NAME_LEN_W = 6;
    localparam int VALUE_W    = 31;
    localparam int KIND_W     = 4;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    // token kinds
    localparam logic [KIND_W-1:0] K_IDENT = 4'd0;
    localparam logic [KIND_W-1:0] K_INT   = 4'd1;
    localparam logic [KIND_W-1:0] K_KWINT = 4'd2;
    localparam logic [KIND_W-1:0] K_KWRET = 4'd3;
    localparam logic [KIND_W-1:0] K_LP    = 4'd4;
    localparam logic [KIND_W-1:0] K_RP    = 4'd5;
    localparam logic [KIND_W-1:0] K_PLUS  = 4'd6;
    localparam logic [KIND_W-1:0] K_MINUS = 4'd7;
    localparam logic [KIND_W-1:0] K_STAR  = 4'd8;
    localparam logic [KIND_W-1:0] K_DIV   = 4'd9;
    localparam logic [KIND_W-1:0] K_EQ    = 4'd10;
    localparam logic [KIND_W-1:0] K_SEMI  = 4'd11;
    localparam logic [KIND_W-1:0] K_EOF   = 4'd12;

    // back-end command codes
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_TOKEN = 2'd1;
    localparam logic [1:0] OP_RUN   = 2'd2;

    // characters
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_LP    = 8'h28;
    localparam logic [7:0] CH_RP    = 8'h29;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_DIV   = 8'h2F;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_EOF   = 8'hFF;

    localparam logic [VALUE_W-1:0] VALUE_MAX = 31'h7FFF_FFFF;

    typedef struct packed {
        logic [1:0]            op;
        logic [KIND_W-1:0]     kind;
        logic [VALUE_W-1:0]    value;
        logic [7:0]            chr;
        logic [NAME_LEN_W-1:0] len;
        logic                  ovf;
    } cmd_t;

endpackage

// File: rtl/csl_front.sv
module csl_front #(
    parameter int MAX_NAME_LEN = 32
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic [7:0]    s_char_code,
    input  logic          s_end_of_text,
    output logic          push_valid,
    input  logic          push_ready,
    output csl_pkg::cmd_t push_cmd
);
    import csl_pkg::*;

    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_NAME = 2'd1;
    localparam logic [1:0] MODE_NUM  = 2'd2;

    logic [1:0]            mode_reg,  mode_next;
    logic [NAME_LEN_W-1:0] count_reg, count_next;
    logic                  ovf_reg,   ovf_next;
    logic [VALUE_W-1:0]    accum_reg, accum_next;
    logic                  mint_reg,  mint_next;
    logic                  mret_reg,  mret_next;
    logic [2:0]            pend_v_reg, pend_v_next;
    cmd_t                  pend_reg [3];
    cmd_t                  pend_next [3];

    logic [1:0]  sel;
    logic        push;
    logic        accept;
    logic        is_let, is_dig, add_name, add_dig;
    logic [34:0] dsum;
    cmd_t        f1, mid, f2;
    logic        f1_v, mid_v, f2_v;
    logic [KIND_W-1:0] op_kind;
    logic        op_ok;

    function automatic logic [7:0] kw_int_char(input logic [2:0] idx);
        case (idx)
            3'd0:    kw_int_char = 8'h69;
            3'd1:    kw_int_char = 8'h6E;
            3'd2:    kw_int_char = 8'h74;
            default: kw_int_char = 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] kw_ret_char(input logic [2:0] idx);
        case (idx)
            3'd0:    kw_ret_char = 8'h72;
            3'd1:    kw_ret_char = 8'h65;
            3'd2:    kw_ret_char = 8'h74;
            3'd3:    kw_ret_char = 8'h75;
            3'd4:    kw_ret_char = 8'h72;
            3'd5:    kw_ret_char = 8'h6E;
            default: kw_ret_char = 8'h00;
        endcase
    endfunction

    function automatic cmd_t make_flush(input logic [1:0] mode,
                                        input logic [NAME_LEN_W-1:0] count,
                                        input logic ovf,
                                        input logic [VALUE_W-1:0] accum,
                                        input logic mint,
                                        input logic mret);
        cmd_t r;
        r = '0;
        if (mode == MODE_NAME) begin
            if (!ovf && count == 6'd3 && mint) begin
                r.op = OP_TOKEN;
                r.kind = K_KWINT;
            end else if (!ovf && count == 6'd6 && mret) begin
                r.op = OP_TOKEN;
                r.kind = K_KWRET;
            end else begin
                r.op = OP_RUN;
                r.kind = K_IDENT;
                r.len = count;
                r.ovf = ovf;
            end
        end else begin
            r.op = OP_TOKEN;
            r.kind = K_INT;
            r.value = accum;
            r.ovf = ovf;
        end
        return r;
    endfunction

    // oldest pending command goes first
    always_comb begin
        if (pend_v_reg[0]) begin
            sel = 2'd0;
        end else if (pend_v_reg[1]) begin
            sel = 2'd1;
        end else begin
            sel = 2'd2;
        end
    end

    assign push_valid = |pend_v_reg;
    assign push_cmd   = pend_reg[sel];
    assign push       = push_valid && push_ready;
    assign s_ready    = (pend_v_reg == 3'b000) ||
                        (push && $countones(pend_v_reg) == 1);
    assign accept     = s_valid && s_ready;

    assign is_let = (s_char_code >= 8'h41 && s_char_code <= 8'h5A) ||
                    (s_char_code >= 8'h61 && s_char_code <= 8'h7A);
    assign is_dig = (s_char_code >= 8'h30 && s_char_code <= 8'h39);

    always_comb begin
        case (s_char_code)
            CH_LP:    begin op_kind = K_LP;    op_ok = 1'b1; end
            CH_RP:    begin op_kind = K_RP;    op_ok = 1'b1; end
            CH_PLUS:  begin op_kind = K_PLUS;  op_ok = 1'b1; end
            CH_MINUS: begin op_kind = K_MINUS; op_ok = 1'b1; end
            CH_STAR:  begin op_kind = K_STAR;  op_ok = 1'b1; end
            CH_DIV:   begin op_kind = K_DIV;   op_ok = 1'b1; end
            CH_EQ:    begin op_kind = K_EQ;    op_ok = 1'b1; end
            CH_SEMI:  begin op_kind = K_SEMI;  op_ok = 1'b1; end
            CH_EOF:   begin op_kind = K_EOF;   op_ok = 1'b1; end
            default:  begin op_kind = K_IDENT; op_ok = 1'b0; end
        endcase
    end

    always_comb begin
        mode_next  = mode_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        accum_next = accum_reg;
        mint_next  = mint_reg;
        mret_next  = mret_reg;
        f1 = '0;
        f1_v = 1'b0;
        mid = '0;
        mid_v = 1'b0;
        f2 = '0;
        f2_v = 1'b0;
        add_name = 1'b0;
        add_dig = 1'b0;
        dsum = '0;

        if (mode_reg == MODE_NAME && (is_let || s_char_code == CH_UNDER)) begin
            add_name = 1'b1;
        end else if (mode_reg == MODE_NUM && is_dig) begin
            add_dig = 1'b1;
        end else begin
            f1 = make_flush(mode_reg, count_reg, ovf_reg, accum_reg,
                            mint_reg, mret_reg);
            f1_v = (mode_reg != MODE_IDLE);
            mode_next  = MODE_IDLE;
            count_next = '0;
            ovf_next   = 1'b0;
            accum_next = '0;
            mint_next  = 1'b1;
            mret_next  = 1'b1;
            if (is_let) begin
                mode_next = MODE_NAME;
                add_name = 1'b1;
            end else if (is_dig) begin
                mode_next = MODE_NUM;
                add_dig = 1'b1;
            end else begin
                mid.op = OP_TOKEN;
                mid.kind = op_kind;
                mid_v = op_ok;
            end
        end

        if (add_name) begin
            if (count_next < NAME_LEN_W'(MAX_NAME_LEN)) begin
                mid.op  = OP_WRITE;
                mid.chr = s_char_code;
                mid.len = count_next;
                mid_v   = 1'b1;
                mint_next = mint_next && (count_next < 6'd3) &&
                            (s_char_code == kw_int_char(count_next[2:0]));
                mret_next = mret_next && (count_next < 6'd6) &&
                            (s_char_code == kw_ret_char(count_next[2:0]));
                count_next = count_next + 6'd1;
            end else begin
                ovf_next = 1'b1;
            end
        end

        if (add_dig) begin
            dsum = ({4'd0, accum_next} << 3) + ({4'd0, accum_next} << 1) +
                   {31'd0, s_char_code[3:0]};
            if (dsum > {4'd0, VALUE_MAX}) begin
                accum_next = VALUE_MAX;
                ovf_next = 1'b1;
            end else begin
                accum_next = dsum[VALUE_W-1:0];
            end
        end

        if (s_end_of_text) begin
            f2 = make_flush(mode_next, count_next, ovf_next, accum_next,
                            mint_next, mret_next);
            f2_v = (mode_next != MODE_IDLE);
            mode_next  = MODE_IDLE;
            count_next = '0;
            ovf_next   = 1'b0;
            accum_next = '0;
            mint_next  = 1'b1;
            mret_next  = 1'b1;
        end
    end

    always_comb begin
        pend_v_next = pend_v_reg;
        pend_next[0] = pend_reg[0];
        pend_next[1] = pend_reg[1];
        pend_next[2] = pend_reg[2];
        if (push) begin
            pend_v_next[sel] = 1'b0;
        end
        if (accept) begin
            pend_v_next = {f2_v, mid_v, f1_v};
            pend_next[0] = f1;
            pend_next[1] = mid;
            pend_next[2] = f2;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_IDLE;
            count_reg  <= '0;
            ovf_reg    <= 1'b0;
            accum_reg  <= '0;
            mint_reg   <= 1'b1;
            mret_reg   <= 1'b1;
            pend_v_reg <= '0;
        end else begin
            pend_v_reg <= pend_v_next;
            if (accept) begin
                mode_reg  <= mode_next;
                count_reg <= count_next;
                ovf_reg   <= ovf_next;
                accum_reg <= accum_next;
                mint_reg  <= mint_next;
                mret_reg  <= mret_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        pend_reg[0] <= pend_next[0];
        pend_reg[1] <= pend_next[1];
        pend_reg[2] <= pend_next[2];
    end

endmodule

// File: rtl/csl_queue.sv
module csl_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push_valid,
    output logic          push_ready,
    input  csl_pkg::cmd_t push_cmd,
    output logic          pop_valid,
    input  logic          pop_ready,
    output csl_pkg::cmd_t pop_cmd
);
    import csl_pkg::*;

    cmd_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   fill_reg,   fill_next;
    logic              do_push, do_pop;

    assign push_ready = (fill_reg != (QPTR_W+1)'(QUEUE_DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_cmd    = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push && !do_pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// File: rtl/csl_back.sv
module csl_back #(
    parameter int MAX_NAME_LEN = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            pop_valid,
    output logic                            pop_ready,
    input  csl_pkg::cmd_t                   pop_cmd,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [csl_pkg::KIND_W-1:0]      m_token_kind,
    output logic [csl_pkg::VALUE_W-1:0]     m_int_value,
    output logic [7:0]                      m_name_char,
    output logic [csl_pkg::NAME_LEN_W-1:0]  m_name_length,
    output logic                            m_run_last,
    output logic                            m_overflow_flag
);
    import csl_pkg::*;

    localparam int IDX_W = $clog2(MAX_NAME_LEN);

    localparam logic [1:0] B_IDLE = 2'd0;
    localparam logic [1:0] B_READ = 2'd1;
    localparam logic [1:0] B_SEND = 2'd2;

    logic [7:0]            name_mem [MAX_NAME_LEN];
    logic [7:0]            rd_reg;
    logic [1:0]            state_reg, state_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic [NAME_LEN_W-1:0] len_reg;
    logic                  rovf_reg;

    logic                  valid_reg, valid_next;
    logic [KIND_W-1:0]     kind_reg;
    logic [VALUE_W-1:0]    value_reg;
    logic [7:0]            chr_reg;
    logic [NAME_LEN_W-1:0] olen_reg;
    logic                  last_reg;
    logic                  oovf_reg;

    logic out_free, pop, load_tok, load_run, run_end;

    assign out_free  = !valid_reg || m_ready;
    assign pop_ready = (state_reg == B_IDLE) &&
                       (pop_cmd.op != OP_TOKEN || out_free);
    assign pop       = pop_valid && pop_ready;
    assign load_tok  = pop && pop_cmd.op == OP_TOKEN;
    assign load_run  = (state_reg == B_SEND) && out_free;
    assign run_end   = (NAME_LEN_W'(idx_reg) + 6'd1) == len_reg;

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        valid_next = valid_reg && !m_ready;
        case (state_reg)
            B_IDLE: begin
                if (pop && pop_cmd.op == OP_RUN) begin
                    state_next = B_READ;
                    idx_next = '0;
                end
            end
            B_READ: begin
                state_next = B_SEND;
            end
            B_SEND: begin
                if (out_free) begin
                    if (run_end) begin
                        state_next = B_IDLE;
                    end else begin
                        state_next = B_READ;
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            default: begin
                state_next = B_IDLE;
            end
        endcase
        if (load_tok || load_run) begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_IDLE;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg <= idx_next;
        if (pop && pop_cmd.op == OP_RUN) begin
            len_reg  <= pop_cmd.len;
            rovf_reg <= pop_cmd.ovf;
        end
        if (load_tok) begin
            kind_reg  <= pop_cmd.kind;
            value_reg <= pop_cmd.value;
            chr_reg   <= '0;
            olen_reg  <= '0;
            last_reg  <= 1'b1;
            oovf_reg  <= pop_cmd.ovf;
        end else if (load_run) begin
            kind_reg  <= K_IDENT;
            value_reg <= '0;
            chr_reg   <= rd_reg;
            olen_reg  <= len_reg;
            last_reg  <= run_end;
            oovf_reg  <= rovf_reg;
        end
    end

    // name buffer
    always_ff @(posedge aclk) begin
        if (pop && pop_cmd.op == OP_WRITE) begin
            name_mem[pop_cmd.len[IDX_W-1:0]] <= pop_cmd.chr;
        end
        if (state_reg == B_READ) begin
            rd_reg <= name_mem[idx_reg];
        end
    end

    assign m_valid         = valid_reg;
    assign m_token_kind    = kind_reg;
    assign m_int_value     = value_reg;
    assign m_name_char     = chr_reg;
    assign m_name_length   = olen_reg;
    assign m_run_last      = last_reg;
    assign m_overflow_flag = oovf_reg;

endmodule

// File: rtl/c_subset_lexer_top.sv
// tokenizer for a small c subset, one source byte per request
// input channel s_*: s_char_code (255 = end of file) and s_end_of_text,
// which flushes any pending identifier or integer after that byte
// result channel m_*: one result per operator, integer, keyword or eof
// token; an identifier gives one result per stored character, with
// m_run_last high on its final character
// a byte is split into at most three commands that go one per cycle,
// while the queue has room, into a four-entry queue, so a byte that ends
// one token and starts another holds the input until the last is pushed
// the back end writes name characters into the name buffer, sends a
// single-result token straight to its output register and an identifier
// run one character at a time (buffer read, then output register)
// a single-result token passes the front end's pending register, a queue
// slot and the output register; an identifier run adds a buffer read
// when m_ready is low the output register holds, the queue fills and
// s_ready drops; no result is lost or repeated
// reset (aresetn low, synchronous) returns to no pending token and
// empties the queue and the output register
module c_subset_lexer_top #(
    parameter int MAX_NAME_LEN = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [7:0]                      s_char_code,
    input  logic                            s_end_of_text,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [csl_pkg::KIND_W-1:0]      m_token_kind,
    output logic [csl_pkg::VALUE_W-1:0]     m_int_value,
    output logic [7:0]                      m_name_char,
    output logic [csl_pkg::NAME_LEN_W-1:0]  m_name_length,
    output logic                            m_run_last,
    output logic                            m_overflow_flag
);
    import csl_pkg::*;

    logic push_valid, push_ready, pop_valid, pop_ready;
    cmd_t push_cmd, pop_cmd;

    csl_front #(
        .MAX_NAME_LEN (MAX_NAME_LEN)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_char_code   (s_char_code),
        .s_end_of_text (s_end_of_text),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_cmd      (push_cmd)
    );

    csl_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    csl_back #(
        .MAX_NAME_LEN (MAX_NAME_LEN)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .pop_valid       (pop_valid),
        .pop_ready       (pop_ready),
        .pop_cmd         (pop_cmd),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_token_kind    (m_token_kind),
        .m_int_value     (m_int_value),
        .m_name_char     (m_name_char),
        .m_name_length   (m_name_length),
        .m_run_last      (m_run_last),
        .m_overflow_flag (m_overflow_flag)
    );

endmodule

// File: tb/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import csl_pkg::*;

    localparam int NAME_MAX    = 32;
    localparam int CYCLE_LIMIT = 10_000_000;

    typedef enum logic [1:0] {
        SCAN_IDLE,
        SCAN_NAME,
        SCAN_NUM
    } scan_mode_t;

    typedef struct {
        logic [KIND_W-1:0]     kind;
        logic [VALUE_W-1:0]    value;
        logic [7:0]            chr;
        logic [NAME_LEN_W-1:0] len;
        logic                  last;
        logic                  ovf;
    } lex_token_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic [7:0]            s_char_code;
    logic                  s_end_of_text;
    logic                  m_valid;
    logic                  m_ready;
    logic [KIND_W-1:0]     m_token_kind;
    logic [VALUE_W-1:0]    m_int_value;
    logic [7:0]            m_name_char;
    logic [NAME_LEN_W-1:0] m_name_length;
    logic                  m_run_last;
    logic                  m_overflow_flag;

    c_subset_lexer_top #(
        .MAX_NAME_LEN(NAME_MAX)
    ) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_char_code    (s_char_code),
        .s_end_of_text  (s_end_of_text),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_token_kind   (m_token_kind),
        .m_int_value    (m_int_value),
        .m_name_char    (m_name_char),
        .m_name_length  (m_name_length),
        .m_run_last     (m_run_last),
        .m_overflow_flag(m_overflow_flag)
    );

    // lexer shadow state
    scan_mode_t            scan_mode = SCAN_IDLE;
    logic [7:0]            name_buf [NAME_MAX];
    int                    name_cnt  = 0;
    logic [VALUE_W-1:0]    num_acc   = '0;
    logic                  ovf_seen  = 1'b0;

    lex_token_t            expected_tokens [$];
    int                    errors    = 0;
    int                    sent_cnt  = 0;
    longint                cycle_cnt = 0;
    bit                    src_free  = 1'b0;
    bit                    sink_free = 1'b0;

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic bit is_letter(logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic bit is_numeral(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic void push_token(logic [KIND_W-1:0] kind, logic [VALUE_W-1:0] value,
                                       logic [7:0] chr, logic [NAME_LEN_W-1:0] len,
                                       logic last, logic ovf);
        lex_token_t t;
        t.kind  = kind;
        t.value = value;
        t.chr   = chr;
        t.len   = len;
        t.last  = last;
        t.ovf   = ovf;
        expected_tokens.insert(expected_tokens.size(), t);
    endfunction

    function automatic bit name_matches(string word);
        bit ok;
        ok = !ovf_seen && name_cnt == word.len();
        for (int i = 0; i < word.len() && ok; i++) begin
            if (name_buf[i] != word[i]) ok = 1'b0;
        end
        return ok;
    endfunction

    function automatic void emit_pending();
        if (scan_mode == SCAN_NAME) begin
            if (name_matches("int")) begin
                push_token(K_KWINT, '0, '0, '0, 1'b1, 1'b0);
            end else if (name_matches("return")) begin
                push_token(K_KWRET, '0, '0, '0, 1'b1, 1'b0);
            end else begin
                for (int i = 0; i < name_cnt; i++) begin
                    push_token(K_IDENT, '0, name_buf[i], name_cnt[NAME_LEN_W-1:0],
                               (i + 1 == name_cnt), ovf_seen);
                end
            end
        end else if (scan_mode == SCAN_NUM) begin
            push_token(K_INT, num_acc, '0, '0, 1'b1, ovf_seen);
        end
        scan_mode = SCAN_IDLE;
        name_cnt  = 0;
        num_acc   = '0;
        ovf_seen  = 1'b0;
    endfunction

    function automatic void store_name_char(logic [7:0] c);
        if (name_cnt < NAME_MAX) begin
            name_buf[name_cnt] = c;
            name_cnt++;
        end else begin
            ovf_seen = 1'b1;
        end
    endfunction

    function automatic void accumulate_digit(logic [7:0] c);
        longint unsigned v;
        v = num_acc;
        v = v * 10 + (c - 8'h30);
        if (v > VALUE_MAX) begin
            v = VALUE_MAX;
            ovf_seen = 1'b1;
        end
        num_acc = v[VALUE_W-1:0];
    endfunction

    function automatic void lex_byte(logic [7:0] c, logic eot);
        logic [KIND_W-1:0] op_kind;
        bit                is_op;
        op_kind = K_IDENT;
        if (scan_mode == SCAN_NAME && (is_letter(c) || c == CH_UNDER)) begin
            store_name_char(c);
        end else if (scan_mode == SCAN_NUM && is_numeral(c)) begin
            accumulate_digit(c);
        end else begin
            emit_pending();
            if (is_letter(c)) begin
                scan_mode = SCAN_NAME;
                store_name_char(c);
            end else if (is_numeral(c)) begin
                scan_mode = SCAN_NUM;
                accumulate_digit(c);
            end else begin
                is_op = 1'b1;
                case (c)
                    CH_LP:    op_kind = K_LP;
                    CH_RP:    op_kind = K_RP;
                    CH_PLUS:  op_kind = K_PLUS;
                    CH_MINUS: op_kind = K_MINUS;
                    CH_STAR:  op_kind = K_STAR;
                    CH_DIV:   op_kind = K_DIV;
                    CH_EQ:    op_kind = K_EQ;
                    CH_SEMI:  op_kind = K_SEMI;
                    CH_EOF:   op_kind = K_EOF;
                    default:  is_op = 1'b0;
                endcase
                if (is_op) push_token(op_kind, '0, '0, '0, 1'b1, 1'b0);
            end
        end
        if (eot) emit_pending();
    endfunction

    function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s expected %0d actual %0d", $realtime, field, want, got);
        end
    endfunction

    always @(posedge aclk) begin : monitor
        lex_token_t want;
        cycle_cnt++;
        if (aresetn) begin
            if (s_valid && s_ready) lex_byte(s_char_code, s_end_of_text);
            if (m_valid && m_ready) begin
                if (expected_tokens.size() == 0) begin
                    errors++;
                    $display("%0t: token_kind expected none actual %0d",
                             $realtime, m_token_kind);
                end else begin
                    want = expected_tokens.pop_front();
                    check_field("token_kind", want.kind, m_token_kind);
                    check_field("int_value", want.value, m_int_value);
                    check_field("name_char", want.chr, m_name_char);
                    check_field("name_length", want.len, m_name_length);
                    check_field("run_last", want.last, m_run_last);
                    check_field("overflow_flag", want.ovf, m_overflow_flag);
                end
            end
        end
    end

    initial begin : watchdog
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("c_subset_lexer_top: mismatch");
        $finish;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    initial begin : result_sink
        int hold;
        m_ready = 1'b0;
        hold = 0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold > 0) begin
                hold--;
            end else if (sink_free || $urandom_range(0, 2) != 0) begin
                m_ready <= 1'b1;
                hold = $urandom_range(0, 6);
            end else begin
                m_ready <= 1'b0;
                hold = gap_len();
            end
        end
    end

    task automatic send_byte(logic [7:0] c, logic eot);
        int gap;
        @(negedge aclk);
        s_valid       <= 1'b1;
        s_char_code   <= c;
        s_end_of_text <= eot;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent_cnt++;
        gap = src_free ? 0 : gap_len();
        if (gap > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
    endtask

    task automatic send_text(string s, logic eot);
        for (int i = 0; i < s.len(); i++) begin
            send_byte(s[i], eot && (i == s.len() - 1));
        end
    endtask

    function automatic logic [7:0] random_letter();
        if ($urandom_range(0, 1)) return 8'("a" + $urandom_range(0, 25));
        return 8'("A" + $urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] random_space();
        case ($urandom_range(0, 2))
            0:       return CH_SPACE;
            1:       return CH_LF;
            default: return CH_TAB;
        endcase
    endfunction

    function automatic logic [7:0] random_operator();
        case ($urandom_range(0, 7))
            0:       return CH_LP;
            1:       return CH_RP;
            2:       return CH_PLUS;
            3:       return CH_MINUS;
            4:       return CH_STAR;
            5:       return CH_DIV;
            6:       return CH_EQ;
            default: return CH_SEMI;
        endcase
    endfunction

    function automatic logic random_eot();
        return $urandom_range(0, 29) == 0;
    endfunction

    task automatic test_operators();
        send_text("( ) + - * / = ;", 1'b0);
        send_byte(CH_EOF, 1'b0);
        send_text(" \t\n", 1'b0);
    endtask

    task automatic test_keywords();
        send_text("int return intx in retur return_ ", 1'b0);
    endtask

    task automatic test_adjacent_tokens();
        send_text("ab1c 12ab", 1'b1);
        send_text("a_b_;", 1'b0);
    endtask

    task automatic test_long_tokens();
        for (int i = 0; i < NAME_MAX + 2; i++) send_byte(random_letter(), 1'b0);
        send_text(" 99999999999 2147483647 2147483648;", 1'b0);
    endtask

    task automatic test_eof_cases();
        send_text("ab", 1'b0);
        send_byte(CH_EOF, 1'b0);
        send_text("12", 1'b0);
        send_byte(CH_EOF, 1'b1);
        send_text("x", 1'b1);
    endtask

    task automatic test_odd_bytes();
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hFE, 1'b0);
        send_byte(CH_UNDER, 1'b0);
        send_byte(CH_SPACE, 1'b1);
        send_byte(CH_SEMI, 1'b1);
        send_text("7", 1'b1);
    endtask

    task automatic test_random_text();
        int pick;
        int len;
        while (sent_cnt < 460) begin
            if ($urandom_range(0, 39) == 0) begin
                src_free  = $urandom_range(0, 3) == 0;
                sink_free = $urandom_range(0, 3) == 0;
            end
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(28, 40)
                                                  : $urandom_range(1, 8);
                send_byte(random_letter(), random_eot());
                for (int i = 1; i < len; i++) begin
                    send_byte(($urandom_range(0, 5) == 0) ? CH_UNDER : random_letter(),
                              random_eot());
                end
            end else if (pick < 38) begin
                send_text($urandom_range(0, 1) ? "int" : "return", random_eot());
            end else if (pick < 58) begin
                len = ($urandom_range(0, 6) == 0) ? $urandom_range(9, 12)
                                                  : $urandom_range(1, 5);
                for (int i = 0; i < len; i++) begin
                    send_byte(8'("0" + $urandom_range(0, 9)), random_eot());
                end
            end else if (pick < 80) begin
                send_byte(random_operator(), random_eot());
            end else if (pick < 92) begin
                send_byte(8'($urandom_range(0, 255)), random_eot());
            end else if (pick < 95) begin
                send_byte(CH_EOF, random_eot());
            end else begin
                send_byte(random_space(), random_eot());
            end
            if ($urandom_range(0, 9) < 5) send_byte(random_space(), random_eot());
        end
        src_free  = 1'b0;
        sink_free = 1'b0;
    endtask

    initial begin
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_char_code   = '0;
        s_end_of_text = 1'b0;
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;

        test_operators();
        test_keywords();
        test_adjacent_tokens();
        test_long_tokens();
        test_eof_cases();
        test_odd_bytes();
        test_random_text();

        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_tokens.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);

        if (errors == 0 && expected_tokens.size() == 0) begin
            $display("c_subset_lexer_top: match");
        end else begin
            $display("c_subset_lexer_top: mismatch");
        end
        $finish;
    end

endmodule
